// ===== rtl/mam_pkg.sv =====
package mam_pkg;

   localparam int SAMPLE_W     = 9;
   localparam int AVG_W        = 9;
   localparam int QUO_W        = AVG_W - 1;
   localparam int WLEN_W       = 11;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int SAMPLE_LIMIT = 200;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI = 9'sd200;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO = -9'sd200;

   // register index, taken from the word-address bit of paddr
   localparam logic CSR_IDX_WINDOW_LEN = 1'b0;

endpackage

// ===== rtl/moving_average_min_max.sv =====
// Sliding-window moving average with min/max tracking over runs of samples.
// Request channel (req_valid/req_ready): one signed sample, clamped to
// -200..200, and a last flag that closes the run. Response channel
// (rsp_valid/rsp_ready): one response per run, sent for the last sample,
// carrying the smallest and largest window average and window_seen.
// window_len is written over the APB port at address 0; the user must write
// it only while the block is idle, which the block does not enforce. The
// write empties the window but keeps the min/max trackers. A request is
// taken in IDLE and passes READ, UPDATE, DIVIDE and FINISH; no new request
// is taken before the block is back in IDLE. The window average comes from
// a bit-serial divider producing one quotient bit per cycle. A request that
// does not yet complete a window skips DIVIDE and the divider.
// The response is registered as the last sample leaves FINISH.
// The response sits in an output register; new requests are taken while it
// waits, and only a further last sample holds until the receiver takes it.
// Reset empties the window, sets window_len to 1 and clears the trackers
// (min 200, max -200). The sample store is not cleared; entries are always
// written before they are read.
module moving_average_min_max #(
   parameter int MAX_WINDOW = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mam_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [mam_pkg::AVG_W-1:0]      rsp_min_avg,
   output logic signed [mam_pkg::AVG_W-1:0]      rsp_max_avg,
   output logic                                  rsp_window_seen,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [mam_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic        [mam_pkg::CSR_DATA_W-1:0] pwdata,
   output logic        [mam_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import mam_pkg::*;

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W = $clog2(SAMPLE_LIMIT * MAX_WINDOW + 1) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic        [WLEN_W-1:0]   wl_ff, wl_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic        [LEN_W-1:0]    fill_ff, fill_in;
   logic        [PTR_W-1:0]    ptr_ff, ptr_in;
   logic signed [AVG_W-1:0]    min_ff, min_in;
   logic signed [AVG_W-1:0]    max_ff, max_in;
   logic                       any_ff, any_in;
   logic signed [SAMPLE_W-1:0] smp_ff, smp_in;
   logic                       last_ff, last_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_W-1:0]    rsp_min_ff, rsp_min_in;
   logic signed [AVG_W-1:0]    rsp_max_ff, rsp_max_in;
   logic                       rsp_seen_ff, rsp_seen_in;

   logic [31:0]                wl_wide;
   logic [LEN_W-1:0]           eff_len;
   logic signed [SAMPLE_W-1:0] sat_sample;
   logic [SAMPLE_W-1:0]        ram_rdata;
   logic signed [SUM_W-1:0]    s_ext, old_ext, sum_upd;
   logic                       full_now, full_after;
   logic [LEN_W-1:0]           fill_upd;
   logic [LEN_W-1:0]           ptr_plus;
   logic [PTR_W-1:0]           ptr_wrap;
   logic                       div_start, div_done;
   logic signed [AVG_W-1:0]    div_quotient;
   logic                       csr_write;
   logic                       rsp_free;

   // window_len of zero acts as one, above MAX_WINDOW as MAX_WINDOW
   assign wl_wide = 32'(wl_ff);
   assign eff_len = (wl_wide == 32'd0)               ? LEN_W'(1) :
                    (wl_wide > 32'(MAX_WINDOW))      ? LEN_W'(MAX_WINDOW) :
                                                       LEN_W'(wl_wide);

   assign sat_sample = (req_sample < SAMPLE_LO) ? SAMPLE_LO :
                       (req_sample > SAMPLE_HI) ? SAMPLE_HI : req_sample;

   assign s_ext      = SUM_W'(smp_ff);
   assign old_ext    = SUM_W'($signed(ram_rdata));
   assign full_now   = fill_ff >= eff_len;
   assign sum_upd    = full_now ? sum_ff + s_ext - old_ext : sum_ff + s_ext;
   assign fill_upd   = full_now ? fill_ff : fill_ff + LEN_W'(1);
   assign full_after = fill_upd >= eff_len;
   assign ptr_plus   = LEN_W'(ptr_ff) + LEN_W'(1);
   assign ptr_wrap   = (ptr_plus == eff_len) ? '0 : ptr_plus[PTR_W-1:0];
   assign div_start  = (state_ff == ST_UPDATE) && full_after;

   assign csr_write = psel && penable && pwrite && (paddr[CSR_ADDR_W-1] == CSR_IDX_WINDOW_LEN);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   mam_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WINDOW),
      .AW    (PTR_W)
   ) u_store (
      .clock (clock),
      .we    (state_ff == ST_UPDATE),
      .waddr (ptr_ff),
      .wdata (smp_ff),
      .raddr (ptr_ff),
      .rdata (ram_rdata)
   );

   mam_div #(
      .SUM_W (SUM_W),
      .LEN_W (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_upd),
      .divisor  (eff_len),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in     = state_ff;
      wl_in        = wl_ff;
      sum_in       = sum_ff;
      fill_in      = fill_ff;
      ptr_in       = ptr_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      any_in       = any_ff;
      smp_in       = smp_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_min_in   = rsp_min_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_seen_in  = rsp_seen_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               smp_in   = sat_sample;
               last_in  = req_last;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            sum_in   = sum_upd;
            fill_in  = fill_upd;
            ptr_in   = ptr_wrap;
            state_in = full_after ? ST_DIVIDE : ST_FINISH;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               if (div_quotient < min_ff) begin
                  min_in = div_quotient;
               end
               if (div_quotient > max_ff) begin
                  max_in = div_quotient;
               end
               any_in   = 1'b1;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = min_ff;
               rsp_max_in   = max_ff;
               rsp_seen_in  = any_ff;
               sum_in       = '0;
               fill_in      = '0;
               ptr_in       = '0;
               min_in       = SAMPLE_HI;
               max_in       = SAMPLE_LO;
               any_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // only written while idle (user duty); empties window, trackers kept
      if (csr_write) begin
         wl_in   = pwdata[WLEN_W-1:0];
         sum_in  = '0;
         fill_in = '0;
         ptr_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wl_ff        <= WLEN_W'(1);
         sum_ff       <= '0;
         fill_ff      <= '0;
         ptr_ff       <= '0;
         min_ff       <= SAMPLE_HI;
         max_ff       <= SAMPLE_LO;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wl_ff        <= wl_in;
         sum_ff       <= sum_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      smp_ff      <= smp_in;
      last_ff     <= last_in;
      rsp_min_ff  <= rsp_min_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_seen_ff <= rsp_seen_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_avg     = rsp_min_ff;
   assign rsp_max_avg     = rsp_max_ff;
   assign rsp_window_seen = rsp_seen_ff;

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_IDX_WINDOW_LEN) ? CSR_DATA_W'(wl_ff) : '0;
   assign pready = 1'b1;

endmodule

// ===== rtl/mam_ram.sv =====
module mam_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mam_div.sv =====
module mam_div #(
   parameter int SUM_W = 19,
   parameter int LEN_W = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [SUM_W-1:0]          dividend,
   input  logic        [LEN_W-1:0]          divisor,
   output logic                             done,
   output logic signed [mam_pkg::AVG_W-1:0] quotient
);
   import mam_pkg::*;

   localparam int MAG_W = SUM_W - 1;
   localparam int CNT_W = $clog2(MAG_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             neg_ff, neg_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             fits;

   // restoring division on the magnitude, one quotient bit per cycle
   assign trial = {rem_ff, mag_ff[MAG_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[SUM_W-1];
         mag_in  = dividend[SUM_W-1] ? MAG_W'(-dividend) : dividend[MAG_W-1:0];
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = CNT_W'(MAG_W);
      end else if (busy_ff) begin
         mag_in = mag_ff << 1;
         rem_in = fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   // truncation toward zero: negate the magnitude quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule
